@@ design/rste_pkg.sv @@
// Shared types, constants and code tables for the remote socket telegram encoder.
// No dependencies; used by rste_cfg_regs and remote_socket_telegram_encoder.
package rste_pkg;

    localparam int unsigned DUR_W      = 16;
    localparam int unsigned CH_W       = 3;
    localparam int unsigned PICK_W     = 2;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned WORD_W     = 24;   // preamble 4 + code 16 + phys 3 + trailer 1
    localparam int unsigned CNT_W      = 6;

    localparam logic [CNT_W-1:0] PULSE_LAST = 6'd49;
    localparam logic [CH_W-1:0]  CH_MAX     = 3'd4;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_PULSE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PULSE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_PAUSE = 2'd2;

    localparam logic [DUR_W-1:0] SHORT_PULSE_RST = 16'd400;
    localparam logic [DUR_W-1:0] LONG_PULSE_RST  = 16'd1200;
    localparam logic [DUR_W-1:0] START_PAUSE_RST = 16'd2400;

    localparam logic [3:0] PREAMBLE = 4'b1100;

    typedef struct packed {
        logic [DUR_W-1:0] dur_short;
        logic [DUR_W-1:0] dur_long;
        logic [DUR_W-1:0] dur_pause;
    } cfg_t;

    function automatic logic [15:0] code_a(input logic [PICK_W-1:0] pick);
        logic [15:0] c;
        case (pick)
            2'd0:    c = 16'h8F24;
            2'd1:    c = 16'hC357;
            2'd2:    c = 16'h57DB;
            default: c = 16'hE5C3;
        endcase
        return c;
    endfunction

    function automatic logic [15:0] code_b(input logic [PICK_W-1:0] pick);
        logic [15:0] c;
        case (pick)
            2'd0:    c = 16'hBABA;
            2'd1:    c = 16'h1842;
            2'd2:    c = 16'h6D01;
            default: c = 16'h42F9;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] phys_channel(input logic [CH_W-1:0] ch);
        logic [2:0] p;
        case (ch)
            3'd0:    p = 3'd0;
            3'd1:    p = 3'd2;
            3'd2:    p = 3'd6;
            3'd3:    p = 3'd1;
            default: p = 3'd5;
        endcase
        return p;
    endfunction

    // Bit sequence of one telegram, first bit sent in the top position
    function automatic logic [WORD_W-1:0] telegram_word(
        input logic [CH_W-1:0]   ch,
        input logic              on,
        input logic [PICK_W-1:0] pick
    );
        logic        use_a;
        logic [15:0] code;
        use_a = (ch < 3'd3) ? on : ~on;
        code  = use_a ? code_a(pick) : code_b(pick);
        return {PREAMBLE, code, phys_channel(ch), 1'b0};
    endfunction

endpackage

@@ design/remote_socket_telegram_encoder.sv @@
// Top level of the remote socket telegram encoder: request intake, pulse sequencer
// and output register. Depends on rste_pkg and rste_cfg_regs.
//
// Usage:
//   A command request on the s_ channel (channel, switch_on, code_pick) becomes one
//   radio telegram of 50 pulse results on the m_ channel. Each result carries the
//   transmitter level and the pulse duration in microseconds; tlast marks the 50th
//   pulse. A command with channel 5..7 gives a single result with tuser (invalid)
//   set, level 0, duration 0 and tlast set.
//   A request is registered in the sequencer, which then loads its first pulse into
//   the output register. Throughput: one pulse per cycle from the output register
//   while m_tready allows it. The next command is accepted in the cycle the final
//   pulse of the current one is loaded, so telegrams run back to back with no gap.
//   The pulse counter of the sequencer counts the pulses of each telegram.
//   Stall: while m_tready is low the output register holds its pulse, the sequencer
//   holds its position and s_tready stays low until the last pulse can be loaded.
//   Reset (aresetn low, synchronous): the sequencer goes idle, the output register
//   empties and the durations return to 400, 1200 and 2400 us.
//   The user must write durations through cfg_wr_en/cfg_index/cfg_wdata while idle (unchecked).
module remote_socket_telegram_encoder (
    input  logic                            aclk,
    input  logic                            aresetn,
    // command requests
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,    // channel[2:0], switch_on[3], code_pick[5:4]
    // pulse results
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [23:0]                     m_tdata,    // level[0], duration_us[16:1]
    output logic                            m_tlast,    // last
    output logic                            m_tuser,    // invalid
    // configuration writes
    input  logic                            cfg_wr_en,
    input  logic [rste_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rste_pkg::DUR_W-1:0]      cfg_wdata
);

    rste_pkg::cfg_t cfg;

    rste_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // unpack the request
    logic [rste_pkg::CH_W-1:0]   s_channel;
    logic                        s_switch_on;
    logic [rste_pkg::PICK_W-1:0] s_code_pick;
    assign s_channel   = s_tdata[2:0];
    assign s_switch_on = s_tdata[3];
    assign s_code_pick = s_tdata[5:4];

    // sequencer state
    logic                          busy_reg, busy_next;
    logic [rste_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [rste_pkg::WORD_W-1:0]   bits_reg, bits_next;
    logic                          inv_reg, inv_next;

    // output register
    logic                          m_valid_reg, m_valid_next;
    logic                          level_reg, level_next;
    logic [rste_pkg::DUR_W-1:0]    dur_reg, dur_next;
    logic                          last_reg, last_next;
    logic                          invalid_reg, invalid_next;

    logic out_load;     // output register can take a pulse this cycle
    logic gen_fire;     // sequencer moves one pulse into the output register
    logic pulse_last;   // current pulse ends the command
    logic s_fire;
    logic half;         // second half of a bit: the low pulse
    logic long_sel;

    assign out_load   = !m_valid_reg || m_tready;
    assign gen_fire   = busy_reg && out_load;
    assign pulse_last = inv_reg || (cnt_reg == rste_pkg::PULSE_LAST);
    assign s_tready   = !busy_reg || (out_load && pulse_last);
    assign s_fire     = s_tvalid && s_tready;

    // Pulses 0 and 1 are the start pulse and pause; from pulse 2 on, even counts
    // are the high half of a bit and odd counts the low half.
    assign half     = cnt_reg[0];
    assign long_sel = bits_reg[rste_pkg::WORD_W-1] ^ half;

    always_comb begin
        level_next   = level_reg;
        dur_next     = dur_reg;
        last_next    = last_reg;
        invalid_next = invalid_reg;
        cnt_next     = cnt_reg;
        bits_next    = bits_reg;
        inv_next     = inv_reg;
        busy_next    = busy_reg;
        m_valid_next = m_valid_reg;

        if (m_tready) begin
            m_valid_next = 1'b0;
        end

        if (gen_fire) begin
            m_valid_next = 1'b1;
            last_next    = pulse_last;
            invalid_next = inv_reg;
            if (inv_reg) begin
                level_next = 1'b0;
                dur_next   = '0;
            end else if (cnt_reg == '0) begin
                level_next = 1'b1;
                dur_next   = cfg.dur_short;
            end else if (cnt_reg == rste_pkg::CNT_W'(1)) begin
                level_next = 1'b0;
                dur_next   = cfg.dur_pause;
            end else begin
                level_next = ~half;
                dur_next   = long_sel ? cfg.dur_long : cfg.dur_short;
                // advance to the next bit after its low half
                if (half) begin
                    bits_next = {bits_reg[rste_pkg::WORD_W-2:0], 1'b0};
                end
            end
            cnt_next = cnt_reg + rste_pkg::CNT_W'(1);
            if (pulse_last) begin
                busy_next = 1'b0;
            end
        end

        if (s_fire) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            bits_next = rste_pkg::telegram_word(s_channel, s_switch_on, s_code_pick);
            inv_next  = (s_channel > rste_pkg::CH_MAX);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg     <= cnt_next;
        bits_reg    <= bits_next;
        inv_reg     <= inv_next;
        level_reg   <= level_next;
        dur_reg     <= dur_next;
        last_reg    <= last_next;
        invalid_reg <= invalid_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, dur_reg, level_reg};
    assign m_tlast  = last_reg;
    assign m_tuser  = invalid_reg;

endmodule

@@ design/rste_cfg_regs.sv @@
// Configuration register bank: pulse and pause durations.
// Depends on rste_pkg.
module rste_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [rste_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rste_pkg::DUR_W-1:0]      cfg_wdata,
    output rste_pkg::cfg_t                  cfg
);

    rste_pkg::cfg_t cfg_reg;
    rste_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                rste_pkg::CFG_SHORT_PULSE: cfg_next.dur_short = cfg_wdata;
                rste_pkg::CFG_LONG_PULSE:  cfg_next.dur_long  = cfg_wdata;
                rste_pkg::CFG_START_PAUSE: cfg_next.dur_pause = cfg_wdata;
                default:                   cfg_next = cfg_reg;   // drop unknown index
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dur_short <= rste_pkg::SHORT_PULSE_RST;
            cfg_reg.dur_long  <= rste_pkg::LONG_PULSE_RST;
            cfg_reg.dur_pause <= rste_pkg::START_PAUSE_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
